// ===== hdl/tlpt_pkg.sv =====
// Package for the two-level page table engine: sizes, codes and shared types.
// Used by tlpt_tbl, two_level_page_table_engine_top and the testbench; depends on nothing else.
`default_nettype none

package tlpt_pkg;

  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int TABLE_POOL    = 64;

  localparam int DIR_AW    = $clog2(DIR_ENTRIES);
  localparam int TIX_W     = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
  localparam int NFS_W     = $clog2(TABLE_POOL + 1);
  localparam int TBL_DEPTH = TABLE_POOL * TABLE_ENTRIES;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int INIT_LEN  = (DIR_ENTRIES > TABLE_ENTRIES) ? DIR_ENTRIES : TABLE_ENTRIES;
  localparam int INIT_W    = $clog2(INIT_LEN);

  localparam int CMD_W       = 2;
  localparam int ADDR_W      = 32;
  localparam int FLAGS_W     = 12;
  localparam int STATUS_W    = 2;
  localparam int RDS_W       = 11;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;

  localparam logic [ADDR_W-1:0]  FRAME_MASK = 32'hFFFF_F000;
  localparam logic [FLAGS_W-1:0] BOOT_FLAGS = 12'h003;
  localparam logic [RDS_W-1:0]   RDS_RESET  = 11'd1023;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP   = 2'd0,
    CMD_UNMAP = 2'd1,
    CMD_XLATE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_RESERVED = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_NO_TABLE = 2'd3
  } status_t;

  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } dir_entry_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] slot;
    logic [TIX_W-1:0]  tix;
    logic [ADDR_W-1:0] wdata;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== hdl/tlpt_tbl.sv =====
// Page table store: the pool of second-level tables in one synchronous memory.
// Forms the entry address from slot and table index; depends on tlpt_pkg.
`default_nettype none

module tlpt_tbl
  import tlpt_pkg::*;
(
  input  wire logic              clk,
  input  wire tbl_req_t          req,
  output logic      [ADDR_W-1:0] rd_data
);

  logic [ADDR_W-1:0] mem [TBL_DEPTH];
  logic [TBL_AW-1:0] addr;

  assign addr = TBL_AW'(TBL_AW'(req.slot) * TBL_AW'(TABLE_ENTRIES)) + TBL_AW'(req.tix);

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/two_level_page_table_engine_top.sv =====
// Two-level page table engine: directory memory, sequencer and stream ports.
// Depends on tlpt_pkg and instantiates tlpt_tbl.
//
// Requests arrive on the s_axis channel and each gives exactly one result on
// the m_axis channel, in order. A request is a no-operation or a map, unmap or translate of one
// virtual address. The directory lives in a 1024-entry memory and the tables
// in a 64K-entry memory, both with a registered read.
// After reset the block runs an initialisation pass that writes the boot
// directory and the identity table; s_axis_tready stays low throughout.
// cfg_we writes the first reserved directory index at any time.
// A refused or no-operation request is finished as it is accepted, a map or
// unmap goes through a directory read, then a table write, and a translate
// through a directory read, a table read and the result. A map that allocates
// a new table sweeps it clear, one entry a cycle, before its result.
// Results sit in an output register; a new request is taken while a result
// waits. If the receiver stalls and the next result is ready, the block
// holds that result and takes no further request until the register frees.
`default_nettype none

module two_level_page_table_engine_top
  import tlpt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // Fields from bit 0: cmd[1:0], virt_addr[33:2], phys_addr[65:34],
  // page_flags[77:66], zero padding.
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // Fields from bit 0: physical_frame[31:0], status[33:32], zero padding.
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [RDS_W-1:0]       cfg_wdata
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOKUP,
    S_CLEAR,
    S_TREAD,
    S_RESULT
  } state_t;

  state_t             state;
  logic [INIT_W-1:0]  cnt;
  logic [NFS_W-1:0]   nfs;
  logic [RDS_W-1:0]   rds;
  cmd_t               cmd_r;
  logic [DIR_AW-1:0]  dix_r;
  logic [TIX_W-1:0]   tix_r;
  logic [ADDR_W-1:0]  entry_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [ADDR_W-1:0]  res_frame;
  status_t            res_status;

  dir_entry_t         dir_mem [DIR_ENTRIES];
  dir_entry_t         dir_q;
  logic               dir_re;
  logic               dir_we;
  logic [DIR_AW-1:0]  dir_waddr;
  dir_entry_t         dir_wdata;

  tbl_req_t           tbl_req;
  logic [ADDR_W-1:0]  tbl_q;

  cmd_t               in_cmd;
  logic [ADDR_W-1:0]  in_va;
  logic [ADDR_W-1:0]  in_pa;
  logic [FLAGS_W-1:0] in_flags;
  logic [9:0]         in_dix;
  logic               in_refused;
  logic               accept;
  logic               out_free;
  logic               pool_empty;
  logic               fin;
  logic [ADDR_W-1:0]  fin_frame;
  status_t            fin_status;

  assign in_cmd   = cmd_t'(s_axis_tdata[1:0]);
  assign in_va    = s_axis_tdata[33:2];
  assign in_pa    = s_axis_tdata[65:34];
  assign in_flags = s_axis_tdata[77:66];
  assign in_dix   = in_va[31:22];
  assign in_refused = ({1'b0, in_dix} >= rds) || (int'(in_dix) >= DIR_ENTRIES);

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign pool_empty    = (nfs >= NFS_W'(TABLE_POOL));

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (dir_re) begin
      dir_q <= dir_mem[in_dix[DIR_AW-1:0]];
    end
  end

  tlpt_tbl u_tbl (
    .clk     (clk),
    .req     (tbl_req),
    .rd_data (tbl_q)
  );

  always_comb begin
    dir_re     = 1'b0;
    dir_we     = 1'b0;
    dir_waddr  = dix_r;
    dir_wdata  = '0;
    tbl_req    = '0;
    fin        = 1'b0;
    fin_frame  = '0;
    fin_status = ST_DONE;
    case (state)
      S_INIT: begin
        dir_we            = (int'(cnt) < DIR_ENTRIES);
        dir_waddr         = cnt[DIR_AW-1:0];
        dir_wdata.present = (cnt == '0);
        tbl_req.we        = (int'(cnt) < TABLE_ENTRIES);
        tbl_req.tix       = cnt[TIX_W-1:0];
        tbl_req.wdata     = (ADDR_W'(cnt[TIX_W-1:0]) << 12) | ADDR_W'(BOOT_FLAGS);
      end
      S_IDLE: begin
        dir_re = s_axis_tvalid;
        if (accept && (in_cmd == CMD_NOP || in_refused)) begin
          fin        = 1'b1;
          fin_status = (in_cmd == CMD_NOP) ? ST_DONE : ST_RESERVED;
        end
      end
      S_LOOKUP: begin
        tbl_req.slot = dir_q.slot;
        tbl_req.tix  = tix_r;
        if (cmd_r == CMD_MAP) begin
          if (dir_q.present) begin
            tbl_req.we    = 1'b1;
            tbl_req.wdata = entry_r;
            fin           = 1'b1;
          end else if (pool_empty) begin
            fin        = 1'b1;
            fin_status = ST_NO_TABLE;
          end else begin
            dir_we            = 1'b1;
            dir_wdata.present = 1'b1;
            dir_wdata.slot    = nfs[SLOT_W-1:0];
          end
        end else if (!dir_q.present) begin
          fin        = 1'b1;
          fin_status = ST_ABSENT;
        end else if (cmd_r == CMD_UNMAP) begin
          tbl_req.we = 1'b1;
          fin        = 1'b1;
        end else begin
          tbl_req.re = 1'b1;
        end
      end
      S_CLEAR: begin
        tbl_req.we    = 1'b1;
        tbl_req.slot  = slot_r;
        tbl_req.tix   = cnt[TIX_W-1:0];
        tbl_req.wdata = (cnt[TIX_W-1:0] == tix_r) ? entry_r : '0;
        fin           = (int'(cnt) == TABLE_ENTRIES - 1);
      end
      S_TREAD: begin
        fin       = 1'b1;
        fin_frame = tbl_q & FRAME_MASK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      cnt           <= '0;
      nfs           <= NFS_W'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (int'(cnt) == INIT_LEN - 1) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= in_cmd;
            dix_r   <= in_dix[DIR_AW-1:0];
            tix_r   <= TIX_W'({1'b0, in_va[21:12]} % 11'(TABLE_ENTRIES));
            entry_r <= (in_pa & FRAME_MASK) | ADDR_W'(in_flags);
            state   <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (cmd_r == CMD_MAP && !dir_q.present && !pool_empty) begin
            slot_r <= nfs[SLOT_W-1:0];
            nfs    <= nfs + 1'b1;
            cnt    <= '0;
            state  <= S_CLEAR;
          end else if (cmd_r == CMD_XLATE && dir_q.present) begin
            state <= S_TREAD;
          end
        end
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
        end
        S_TREAD: begin
        end
        S_RESULT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {{(OUT_TDATA_W - ADDR_W - STATUS_W){1'b0}}, res_status, res_frame};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fin) begin
        if (out_free) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata  <= {{(OUT_TDATA_W - ADDR_W - STATUS_W){1'b0}}, fin_status, fin_frame};
          state         <= S_IDLE;
        end else begin
          res_frame  <= fin_frame;
          res_status <= fin_status;
          state      <= S_RESULT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rds <= RDS_RESET;
    end else if (cfg_we) begin
      rds <= cfg_wdata;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for two_level_page_table_engine_top: a queue-fed stream driver, a result monitor
// and a page table predictor that works out each request's result as it is accepted.
// Depends on tlpt_pkg and the engine RTL only.
`timescale 1ns / 100ps

module tb;
  import tlpt_pkg::*;

  localparam int REQ_BITS      = CMD_W + 2 * ADDR_W + FLAGS_W;
  localparam int PHASE_ITEMS   = 325;
  localparam int STALL_LIMIT   = 12000;

  typedef struct {
    cmd_t                 cmd;
    logic [ADDR_W-1:0]    va;
    logic [ADDR_W-1:0]    pa;
    logic [FLAGS_W-1:0]   flags;
  } page_req_t;

  typedef struct {
    logic [ADDR_W-1:0]    frame;
    status_t              status;
  } page_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [RDS_W-1:0]       cfg_wdata = '0;

  two_level_page_table_engine_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // Predictor state.
  bit                     dir_valid [DIR_ENTRIES];
  logic [SLOT_W-1:0]      dir_slot [DIR_ENTRIES];
  logic [ADDR_W-1:0]      pte_mirror [TBL_DEPTH];
  int unsigned            slots_used;
  logic [RDS_W-1:0]       reserved_from;

  page_req_t              page_requests [$];
  page_result_t           walk_results_due [$];
  logic [ADDR_W-1:0]      recent_va [$];
  int unsigned            mismatches = 0;
  int unsigned            results_seen = 0;

  page_req_t              tx_req;
  int unsigned            tx_wait = 0;
  bit                     tx_burst = 1'b0;
  int unsigned            rx_wait = 0;
  bit                     rx_burst = 1'b0;
  int unsigned            idle_cycles = 0;
  page_result_t           got, want;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pte_index(input int unsigned slot, input int unsigned tix);
    return slot * TABLE_ENTRIES + tix;
  endfunction

  function automatic page_result_t walk_tables(input page_req_t r);
    page_result_t      res;
    logic [DIR_AW-1:0] dix;
    logic [TIX_W-1:0]  tix;
    res.frame  = '0;
    res.status = ST_DONE;
    dix = r.va[ADDR_W-1 -: DIR_AW];
    tix = r.va[12 +: TIX_W];
    if (r.cmd != CMD_NOP) begin
      if (dix >= reserved_from) begin
        res.status = ST_RESERVED;
      end else if (r.cmd == CMD_MAP) begin
        if (!dir_valid[dix] && slots_used >= TABLE_POOL) begin
          res.status = ST_NO_TABLE;
        end else begin
          if (!dir_valid[dix]) begin
            dir_valid[dix] = 1'b1;
            dir_slot[dix]  = slots_used[SLOT_W-1:0];
            for (int i = 0; i < TABLE_ENTRIES; i++) pte_mirror[pte_index(slots_used, i)] = '0;
            slots_used++;
          end
          pte_mirror[pte_index(dir_slot[dix], tix)] = (r.pa & FRAME_MASK) | r.flags;
        end
      end else if (!dir_valid[dix]) begin
        res.status = ST_ABSENT;
      end else if (r.cmd == CMD_UNMAP) begin
        pte_mirror[pte_index(dir_slot[dix], tix)] = '0;
      end else begin
        res.frame = pte_mirror[pte_index(dir_slot[dix], tix)] & FRAME_MASK;
      end
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned p;
    p = $urandom_range(99);
    if (burst || p < 45) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  task automatic push_request(input cmd_t cmd, input logic [ADDR_W-1:0] va,
                              input logic [ADDR_W-1:0] pa, input logic [FLAGS_W-1:0] flags);
    page_req_t r;
    r.cmd   = cmd;
    r.va    = va;
    r.pa    = pa;
    r.flags = flags;
    page_requests.push_back(r);
    if (cmd == CMD_MAP) begin
      recent_va.push_back(va);
      if (recent_va.size() > 24) void'(recent_va.pop_front());
    end
  endtask

  // Mostly revisits recently mapped addresses so that translates and unmaps find live
  // entries; the rest is fresh directories, addresses either side of the reserved
  // boundary and plain noise.
  task automatic push_random_request();
    cmd_t              cmd;
    logic [ADDR_W-1:0] va;
    logic [DIR_AW-1:0] d;
    int unsigned       p, c;
    c = $urandom_range(19);
    if (c < 7) cmd = CMD_MAP;
    else if (c < 10) cmd = CMD_UNMAP;
    else if (c < 19) cmd = CMD_XLATE;
    else cmd = CMD_NOP;
    p  = $urandom_range(99);
    va = $urandom();
    if (p < 55 && recent_va.size() != 0) begin
      va = {recent_va[$urandom_range(recent_va.size() - 1)][ADDR_W-1:12], va[11:0]};
    end else if (p < 80 && recent_va.size() != 0) begin
      va = {recent_va[$urandom_range(recent_va.size() - 1)][ADDR_W-1 -: DIR_AW],
            va[ADDR_W-DIR_AW-1:0]};
    end else if (p >= 92) begin
      d  = DIR_AW'((reserved_from > DIR_ENTRIES - 1 || $urandom_range(1) == 0) ?
                   reserved_from - 1'b1 : reserved_from);
      va = {d, va[ADDR_W-DIR_AW-1:0]};
    end
    push_request(cmd, va, $urandom(), FLAGS_W'($urandom()));
  endtask

  task automatic wait_idle();
    while (page_requests.size() != 0 || s_axis_tvalid || walk_results_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reserved_start(input logic [RDS_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    reserved_from = v;
  endtask

  task automatic report_mismatch(input string what);
    $display("tb: mismatch on result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        walk_results_due.push_back(walk_tables(tx_req));
        tx_wait = pick_gap(tx_burst);
        if ($urandom_range(63) == 0) tx_burst = !tx_burst;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (page_requests.size() != 0) begin
          tx_req = page_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_TDATA_W-REQ_BITS){1'b0}}, tx_req.flags, tx_req.pa,
                            tx_req.va, tx_req.cmd};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got.frame  = m_axis_tdata[ADDR_W-1:0];
        got.status = status_t'(m_axis_tdata[ADDR_W +: STATUS_W]);
        if (walk_results_due.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = walk_results_due.pop_front();
          if (got.frame !== want.frame)
            report_mismatch($sformatf("physical_frame %h, expected %h", got.frame, want.frame));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %s, expected %s", got.status.name(),
                                      want.status.name()));
        end
        rx_wait = pick_gap(rx_burst);
        if ($urandom_range(63) == 0) rx_burst = !rx_burst;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [RDS_W-1:0] rds;
    for (int i = 0; i < DIR_ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_slot[i]  = '0;
    end
    for (int i = 0; i < TBL_DEPTH; i++) pte_mirror[i] = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++)
      pte_mirror[i] = ((i << 12) & FRAME_MASK) | BOOT_FLAGS;
    dir_valid[0]  = 1'b1;
    slots_used    = 1;
    reserved_from = RDS_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Boot identity map, entry overwrite and removal, absent and reserved directories,
    // table allocation and the unused command.
    push_request(CMD_XLATE, 32'h0000_5123, 32'h0, 12'h0);
    push_request(CMD_XLATE, 32'h003F_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    push_request(CMD_MAP,   32'h0000_7ABC, 32'hFFFF_FFFF, 12'hFFF);
    push_request(CMD_XLATE, 32'h0000_7000, 32'h0, 12'h0);
    push_request(CMD_UNMAP, 32'h0000_7FFF, 32'h0, 12'h0);
    push_request(CMD_XLATE, 32'h0000_7000, 32'h0, 12'h0);
    push_request(CMD_XLATE, 32'h0140_0000, 32'h0, 12'h0);
    push_request(CMD_UNMAP, 32'h0140_0000, 32'h0, 12'h0);
    push_request(CMD_MAP,   32'hFFBF_F000, 32'h1234_5FFF, 12'h067);
    push_request(CMD_XLATE, 32'hFFBF_FFFF, 32'h0, 12'h0);
    push_request(CMD_XLATE, 32'hFF80_0000, 32'h0, 12'h0);
    push_request(CMD_MAP,   32'hFFC0_0000, 32'hAAAA_A000, 12'h555);
    push_request(CMD_XLATE, 32'hFFFF_FFFF, 32'h0, 12'h0);
    push_request(CMD_UNMAP, 32'hFFC0_1000, 32'h0, 12'h0);
    push_request(CMD_NOP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    push_request(CMD_MAP,   32'h0040_0000, 32'h0000_0000, 12'h000);
    push_request(CMD_XLATE, 32'h0040_0000, 32'h0, 12'h0);
    push_request(CMD_MAP,   32'h0040_1000, 32'h5555_5123, 12'hAAA);
    push_request(CMD_XLATE, 32'h0040_1FFF, 32'h0, 12'h0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: rds = 11'd1024;
        1: rds = 11'd1;
        3: rds = 11'd600;
        5: rds = RDS_RESET;
        default: rds = RDS_W'($urandom_range(1024, 1));
      endcase
      write_reserved_start(rds);
      repeat (PHASE_ITEMS) push_random_request();
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && walk_results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
